/* sv/rau_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_pkg
// Shared types for the rational arithmetic unit: opcodes, compare codes and
// the sequencer states.
// ---------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_RED = 3'd5
  } rau_op_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } rau_cmp_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_SIGN,
    S_GCD,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_OUT
  } rau_state_e;

endpackage

/* sv/rau_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_div
// Iterative restoring divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for one cycle when the quotient is ready.
// ---------------------------------------------------------------------------
module rau_div #(
  parameter int WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] div_q, div_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH+1:0] diff;
  logic             ge;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = {1'b0, trial} - {2'b00, div_q};
  assign ge    = ~diff[WIDTH+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* sv/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Sequence: the shared multiplier forms three products, S_COMB and S_SIGN set
// up the operands, binary GCD steps follow, then two divisions and the output
// state. Compare and error cases skip GCD and division.
// Throughput: one item at a time; in_stall_o holds new items off until idle.
// The shared multiplier, the GCD subtractor and the one divider set the rate.
// Reset is asynchronous and active low; it clears the sequencer and out valid.
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide, compare and reduce. Results are
// brought to lowest terms by a binary GCD followed by two exact divisions.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      opcode_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-1:0]        a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-1:0]        b_den_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [33:0]              res_num_o,
  output logic [31:0]                     res_den_o,
  output logic [1:0]                      cmp_result_o,
  output logic                            div_zero_o
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W + 2;   // signed products and sums
  localparam int MW = 2 * W + 1;   // magnitudes
  localparam int XW = MW + 34;
  localparam int YW = MW + 32;

  rau_state_e state_q, state_d;
  logic [1:0] mstep_q, mstep_d;
  logic       out_valid_q, out_valid_d;

  rau_op_e                op_q, op_d;
  logic signed [W-1:0]    an_q, an_d, bn_q, bn_d;
  logic [W-1:0]           ad_q, ad_d, bd_q, bd_d;
  logic signed [PW-1:0]   p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic signed [PW-1:0]   num_q, num_d, den_q, den_d;
  logic [MW-1:0]          x_q, x_d, y_q, y_d, m_q, m_d, d_q, d_d;
  logic                   neg_q, neg_d;
  rau_cmp_e               cmp_q, cmp_d;
  logic                   dz_q, dz_d;
  logic signed [33:0]     rn_q, rn_d;
  logic [31:0]            rd_q, rd_d;
  logic [1:0]             rc_q, rc_d;
  logic                   rz_q, rz_d;

  logic signed [W:0]      mul_a, mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   num_abs, den_abs;
  logic [MW-1:0]          big, lil, gdiff;
  logic                   in_take;
  logic                   div_start, div_done;
  logic [MW-1:0]          div_dividend, div_quot;
  logic [XW-1:0]          m_ext, num_full;
  logic [YW-1:0]          d_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // One shared signed multiplier; the step counter picks its operands.
  always_comb begin
    unique case (mstep_q)
      2'd0: begin
        mul_a = {an_q[W-1], an_q};
        mul_b = (op_q == OP_MUL) ? {bn_q[W-1], bn_q} : $signed({1'b0, bd_q});
      end
      2'd1: begin
        mul_a = {bn_q[W-1], bn_q};
        mul_b = $signed({1'b0, ad_q});
      end
      default: begin
        mul_a = $signed({1'b0, ad_q});
        mul_b = $signed({1'b0, bd_q});
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign num_abs = num_q[PW-1] ? -num_q : num_q;
  assign den_abs = den_q[PW-1] ? -den_q : den_q;

  assign big   = (x_q >= y_q) ? x_q : y_q;
  assign lil   = (x_q >= y_q) ? y_q : x_q;
  assign gdiff = big - lil;

  assign div_start    = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO);
  assign div_dividend = (state_q == S_DIVN_GO) ? m_q : d_q;

  rau_div #(
    .WIDTH(MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (x_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign m_ext    = {34'd0, m_q};
  assign num_full = neg_q ? (~m_ext + 1'b1) : m_ext;
  assign d_ext    = {32'd0, d_q};

  always_comb begin
    state_d     = state_q;
    mstep_d     = mstep_q;
    out_valid_d = out_valid_q;
    op_d  = op_q;
    an_d  = an_q;
    ad_d  = ad_q;
    bn_d  = bn_q;
    bd_d  = bd_q;
    p0_d  = p0_q;
    p1_d  = p1_q;
    p2_d  = p2_q;
    num_d = num_q;
    den_d = den_q;
    x_d   = x_q;
    y_d   = y_q;
    m_d   = m_q;
    d_d   = d_q;
    neg_d = neg_q;
    cmp_d = cmp_q;
    dz_d  = dz_q;
    rn_d  = rn_q;
    rd_d  = rd_q;
    rc_d  = rc_q;
    rz_d  = rz_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          op_d    = rau_op_e'(opcode_i);
          an_d    = a_num_i;
          ad_d    = a_den_i;
          bn_d    = b_num_i;
          bd_d    = b_den_i;
          mstep_d = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        unique case (mstep_q)
          2'd0:    p0_d = prod;
          2'd1:    p1_d = prod;
          default: p2_d = prod;
        endcase
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd2) begin
          mstep_d = 2'd0;
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        // Default outcome is 0/1 with no flags; the reducing paths override it.
        m_d     = '0;
        d_d     = MW'(1);
        neg_d   = 1'b0;
        cmp_d   = CMP_LT;
        dz_d    = 1'b0;
        state_d = S_OUT;
        unique case (op_q)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (ad_q == '0 || bd_q == '0 || (op_q == OP_DIV && bn_q == '0)) begin
              dz_d = 1'b1;
            end else begin
              unique case (op_q)
                OP_ADD:  num_d = p0_q + p1_q;
                OP_SUB:  num_d = p0_q - p1_q;
                default: num_d = p0_q;
              endcase
              den_d   = (op_q == OP_DIV) ? p1_q : p2_q;
              state_d = S_SIGN;
            end
          end
          OP_CMP: begin
            if (p0_q < p1_q) begin
              cmp_d = CMP_LT;
            end else if (p0_q > p1_q) begin
              cmp_d = CMP_GT;
            end else begin
              cmp_d = CMP_EQ;
            end
          end
          OP_RED: begin
            if (ad_q == '0) begin
              dz_d = 1'b1;
            end else begin
              num_d   = PW'(an_q);
              den_d   = $signed(PW'(ad_q));
              state_d = S_SIGN;
            end
          end
          default: ;
        endcase
      end
      S_SIGN: begin
        if (num_q == '0) begin
          state_d = S_OUT;
        end else begin
          neg_d   = num_q[PW-1] ^ den_q[PW-1];
          x_d     = num_abs[MW-1:0];
          y_d     = den_abs[MW-1:0];
          m_d     = num_abs[MW-1:0];
          d_d     = den_abs[MW-1:0];
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        // Binary GCD. Common factors of two are stripped from the operands
        // themselves, so the divisor left over is always odd.
        if (x_q == '0 || y_q == '0) begin
          x_d     = x_q | y_q;
          state_d = S_DIVN_GO;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          m_d = m_q >> 1;
          d_d = d_q >> 1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = gdiff;
        end else begin
          y_d = gdiff;
        end
      end
      S_DIVN_GO: begin
        state_d = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (div_done) begin
          m_d     = div_quot;
          state_d = S_DIVD_GO;
        end
      end
      S_DIVD_GO: begin
        state_d = S_DIVD_WAIT;
      end
      S_DIVD_WAIT: begin
        if (div_done) begin
          d_d     = div_quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          rn_d        = $signed(num_full[33:0]);
          rd_d        = d_ext[31:0];
          rc_d        = cmp_q;
          rz_d        = dz_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    num_q <= num_d;
    den_q <= den_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    d_q   <= d_d;
    neg_q <= neg_d;
    cmp_q <= cmp_d;
    dz_q  <= dz_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    rc_q  <= rc_d;
    rz_q  <= rz_d;
  end

  assign out_valid_o  = out_valid_q;
  assign res_num_o    = rn_q;
  assign res_den_o    = rd_q;
  assign cmp_result_o = rc_q;
  assign div_zero_o   = rz_q;

  // The GCD loop never runs with both operands at zero.
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GCD |-> (x_q != '0 || y_q != '0))
    else $error("GCD operands both zero");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVN_WAIT || state_q == S_DIVD_WAIT))
    else $error("divider finished outside a wait state");

  // An error result is always 0/1.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_zero_o) |-> (res_num_o == '0 && res_den_o == 32'd1))
    else $error("error result is not 0/1");

  // A new result is only loaded into a free or draining output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT)
    else $error("result left the sequencer while output stalled");

endmodule
